// ----- hw/rtl/vector_terminal_plot_encoder_macros.svh -----
// Assertion macros for the checker file of the plot encoder.
`ifndef VECTOR_TERMINAL_PLOT_ENCODER_MACROS_SVH
`define VECTOR_TERMINAL_PLOT_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define VTPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

// ----- hw/rtl/vtpe_pkg.sv -----
// Types, codes and byte tables shared by the plot encoder modules.
package vtpe_pkg;

    localparam logic [1:0] FUNC_MOVE  = 2'd0;
    localparam logic [1:0] FUNC_LINE  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_TEXT  = 2'd3;

    localparam logic [2:0] OP_MOVE    = 3'd0;
    localparam logic [2:0] OP_LINE_MV = 3'd1;
    localparam logic [2:0] OP_LINE    = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_TEXT    = 3'd4;

    localparam logic [7:0] CH_GS  = 8'h1D;
    localparam logic [7:0] CH_US  = 8'h1F;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_H   = 8'h48;
    localparam logic [2:0] TAG_HI   = 3'b001;
    localparam logic [2:0] TAG_LO_Y = 3'b011;
    localparam logic [2:0] TAG_LO_X = 3'b010;

    localparam int CoordW = 10;
    localparam int IdxW   = 4;

    typedef struct packed {
        logic [2:0]        op;
        logic [CoordW-1:0] old_x;
        logic [CoordW-1:0] old_y;
        logic [CoordW-1:0] new_x;
        logic [CoordW-1:0] new_y;
    } job_t;

    function automatic logic [IdxW-1:0] job_len(input logic [2:0] op);
        logic [IdxW-1:0] n;
        case (op)
            OP_MOVE:    n = 4'd5;
            OP_LINE_MV: n = 4'd9;
            OP_LINE:    n = 4'd4;
            OP_CLEAR:   n = 4'd2;
            OP_TEXT:    n = 4'd4;
            default:    n = 4'd2;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] coord_byte(input logic [CoordW-1:0] cx,
                                              input logic [CoordW-1:0] cy,
                                              input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = {TAG_HI, cy[9:5]};
            2'd1:    b = {TAG_LO_Y, cy[4:0]};
            2'd2:    b = {TAG_HI, cx[9:5]};
            default: b = {TAG_LO_X, cx[4:0]};
        endcase
        return b;
    endfunction

    function automatic logic [7:0] job_byte(input job_t j, input logic [IdxW-1:0] idx);
        logic [7:0]      b;
        logic [IdxW-1:0] m1;
        logic [IdxW-1:0] m5;
        m1 = idx - 4'd1;
        m5 = idx - 4'd5;
        case (j.op)
            OP_MOVE:
                b = (idx == 4'd0) ? CH_GS : coord_byte(j.new_x, j.new_y, m1[1:0]);
            OP_LINE_MV:
                if (idx == 4'd0)
                    b = CH_GS;
                else if (idx < 4'd5)
                    b = coord_byte(j.old_x, j.old_y, m1[1:0]);
                else
                    b = coord_byte(j.new_x, j.new_y, m5[1:0]);
            OP_LINE:
                b = coord_byte(j.new_x, j.new_y, idx[1:0]);
            OP_CLEAR:
                b = (idx == 4'd0) ? CH_ESC : CH_FF;
            OP_TEXT:
                case (idx[1:0])
                    2'd0:    b = CH_US;
                    2'd1:    b = CH_ESC;
                    2'd2:    b = CH_LBR;
                    default: b = CH_H;
                endcase
            default:
                b = CH_ESC;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/vtpe_front.sv -----
// Command front end: tracks mode and pen position and turns commands into jobs.
module vtpe_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic [vtpe_pkg::CoordW-1:0] x,
    input  logic [vtpe_pkg::CoordW-1:0] y,
    input  logic                       q_full,
    output logic                       push,
    output vtpe_pkg::job_t             push_job
);
    import vtpe_pkg::*;

    logic              gm_reg, gm_next;
    logic [CoordW-1:0] pen_x_reg, pen_x_next;
    logic [CoordW-1:0] pen_y_reg, pen_y_next;
    logic              take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        gm_next        = gm_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        push           = 1'b0;
        push_job.op    = OP_CLEAR;
        push_job.old_x = pen_x_reg;
        push_job.old_y = pen_y_reg;
        push_job.new_x = x;
        push_job.new_y = y;
        if (take)
        begin
            case (func)
                FUNC_MOVE:
                begin
                    push_job.op = OP_MOVE;
                    push        = 1'b1;
                    gm_next     = 1'b1;
                    pen_x_next  = x;
                    pen_y_next  = y;
                end
                FUNC_LINE:
                begin
                    push_job.op = gm_reg ? OP_LINE : OP_LINE_MV;
                    push        = 1'b1;
                    gm_next     = 1'b1;
                    pen_x_next  = x;
                    pen_y_next  = y;
                end
                FUNC_CLEAR:
                begin
                    push_job.op = OP_CLEAR;
                    push        = 1'b1;
                    gm_next     = 1'b0;
                end
                default:
                begin
                    push_job.op = OP_TEXT;
                    push        = gm_reg;
                    gm_next     = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gm_reg    <= 1'b0;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end
        else
        begin
            gm_reg    <= gm_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
        end
    end

endmodule

// ----- hw/rtl/vtpe_queue.sv -----
// Two-entry job queue between the front end and the byte sequencer.
module vtpe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vtpe_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output vtpe_pkg::job_t head
);
    import vtpe_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/vtpe_back.sv -----
// Byte sequencer: walks each job and drives the registered output byte stream.
module vtpe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  vtpe_pkg::job_t q_head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           last
);
    import vtpe_pkg::*;

    logic            busy_reg, busy_next;
    job_t            job_reg, job_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            last_reg, last_next;

    job_t            cur_job;
    logic [IdxW-1:0] cur_idx;
    logic            have, can_load, emit, is_last;

    assign cur_job  = busy_reg ? job_reg : q_head;
    assign cur_idx  = busy_reg ? idx_reg : '0;
    assign have     = busy_reg || q_not_empty;
    assign can_load = !out_valid_reg || out_ready;
    assign emit     = have && can_load;
    assign is_last  = (cur_idx == job_len(cur_job.op) - 4'd1);
    assign pop      = emit && !busy_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (can_load)
        begin
            out_valid_next = have;
        end
        if (emit)
        begin
            out_byte_next = job_byte(cur_job, cur_idx);
            last_next     = is_last;
            busy_next     = !is_last;
            job_next      = cur_job;
            idx_next      = cur_idx + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

// ----- hw/rtl/vector_terminal_plot_encoder.sv -----
// Top level of the vector terminal plot encoder.
// Commands (func, x, y) arrive on the input channel (in_valid, in_ready);
// each accepted transfer is one command: move, draw line, clear or text.
// Terminal bytes leave on the output channel (out_valid, out_ready) as
// out_byte, with last set on the final byte that a command produces.
// A move gives five bytes, a line four, or nine when it must first reopen
// graphics mode, a clear two, and text four, or none outside graphics mode.
// The first byte of a command passes through a queue entry and then the
// output byte register. The output runs at one byte per cycle while
// out_ready is high.
// A two-entry job queue decouples the command side from the byte side, so
// new commands are taken while earlier bytes are still going out.
// When the receiver stalls, the current byte holds and the queue fills;
// in_ready drops once both queue entries are occupied.
// Reset puts the block in text mode with the pen at the origin and clears
// the queue and the output stage.
module vector_terminal_plot_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic [vtpe_pkg::CoordW-1:0] x,
    input  logic [vtpe_pkg::CoordW-1:0] y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte,
    output logic                       last
);
    import vtpe_pkg::*;

    logic q_full, push, pop, q_not_empty;
    job_t push_job, q_head;

    vtpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .x        (x),
        .y        (y),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    vtpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    vtpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

endmodule

// ----- hw/rtl/vtpe_checker.sv -----
// Port-level checker for the plot encoder and its bind statement.
`include "vector_terminal_plot_encoder_macros.svh"

module vtpe_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [1:0]                 func,
    input logic [vtpe_pkg::CoordW-1:0] x,
    input logic [vtpe_pkg::CoordW-1:0] y,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [7:0]                 out_byte,
    input logic                       last
);
    import vtpe_pkg::*;

    // A stalled output byte must stay put.
    `VTPE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last))
    // GS always opens a sequence, so it is never the final byte.
    `VTPE_ASSERT_NOW(a_gs_not_last, clk, rst_n, out_valid && out_byte == CH_GS, !last)
    // Form feed only ends a clear.
    `VTPE_ASSERT_NOW(a_ff_last, clk, rst_n, out_valid && out_byte == CH_FF, last)
    // Escape is always followed by more bytes of the same command.
    `VTPE_ASSERT_NOW(a_esc_not_last, clk, rst_n, out_valid && out_byte == CH_ESC, !last)

endmodule

bind vector_terminal_plot_encoder vtpe_checker u_vtpe_checker (.*);
